// ----- rtl/sha1he_pkg.sv -----
// Shared types and constants for the SHA-1 hash engine.
// Used by the schedule window, the round unit and the top level; no dependencies.
package sha1he_pkg;

   typedef logic [31:0] word_type;

   localparam int CHAIN_WORDS = 5;

   localparam word_type CHAIN_INIT [CHAIN_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam word_type ROUND_K0 = 32'h5a827999;
   localparam word_type ROUND_K1 = 32'h6ed9eba1;
   localparam word_type ROUND_K2 = 32'h8f1bbcdc;
   localparam word_type ROUND_K3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [6:0] LAST_ROUND = 7'd79;

   // Controls for the round unit.
   typedef struct packed {
      logic       init;   // reload chaining words with the initial values
      logic       load;   // working variables take the chaining words
      logic       step;   // one compression round
      logic       fold;   // add working variables into the chaining words
      logic [6:0] round;
   } rnd_ctrl_type;

   // Controls for the message schedule window.
   typedef struct packed {
      logic       push;      // one buffer byte enters
      logic       word_end;  // that byte completes a big-endian word
      logic [7:0] data;
      logic       shift;     // advance the window by one round
   } sched_ctrl_type;

endpackage

// ----- rtl/sha1he_sched.sv -----
// Block buffer and message schedule of the SHA-1 hash engine: a 16-word shift line.
// Depends on sha1he_pkg.
module sha1he_sched
   import sha1he_pkg::*;
(
   input  logic           clock,
   input  sched_ctrl_type ctrl,
   output word_type       w_cur
);

   logic [23:0] acc_ff;
   logic [23:0] acc_in;
   word_type    win_ff [16];
   word_type    win_in [16];
   word_type    mix;
   word_type    feed;

   assign mix  = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign feed = ctrl.shift ? {mix[30:0], mix[31]} : {acc_ff, ctrl.data};

   always_comb begin
      acc_in = acc_ff;
      win_in = win_ff;
      if (ctrl.push) begin
         acc_in = {acc_ff[15:0], ctrl.data};
      end
      // A finished word or a new schedule word enters at the top.
      if ((ctrl.push && ctrl.word_end) || ctrl.shift) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = feed;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      win_ff <= win_in;
   end

   assign w_cur = win_ff[0];

endmodule

// ----- rtl/sha1he_round.sv -----
// Shared SHA-1 round unit with the working variables and the chaining words.
// Depends on sha1he_pkg.
module sha1he_round
   import sha1he_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rnd_ctrl_type ctrl,
   input  word_type     w_cur,
   output word_type     chain_words [CHAIN_WORDS]
);

   word_type chain_ff [CHAIN_WORDS];
   word_type chain_in [CHAIN_WORDS];
   word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type a_in, b_in, c_in, d_in, e_in;
   word_type f_val;
   word_type k_val;
   word_type t_val;

   always_comb begin
      if (ctrl.round < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = ROUND_K0;
      end else if (ctrl.round < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = ROUND_K1;
      end else if (ctrl.round < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = ROUND_K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = ROUND_K3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      chain_in = chain_ff;
      if (ctrl.load) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (ctrl.step) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
      if (ctrl.init) begin
         chain_in = CHAIN_INIT;
      end else if (ctrl.fold) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= CHAIN_INIT;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign chain_words = chain_ff;

endmodule

// ----- rtl/sha1_hash_engine.sv -----
// SHA-1 hash engine. A message byte is taken whenever req_stall is low. Each 64th
// byte starts the compression: the 80 rounds of the single shared round unit, then
// a fold of the result into the chaining words, with req_stall high throughout. A
// request with last_byte set then writes the padding and length one byte per cycle
// through the same path, compresses one or two more blocks, and presents the digest
// as five words on the rsp channel, index 0 first; the engine takes no request until
// the fifth word is accepted, then starts the next message from the initial state.
// Depends on sha1he_pkg, sha1he_sched and sha1he_round.
module sha1_hash_engine
   import sha1he_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_end
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_FOLD  = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [60:0] count_ff, count_in;
   logic [5:0]  fill_ff, fill_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        pend_last_ff, pend_last_in;
   logic        in_pad_ff, in_pad_in;
   logic        pad_first_ff, pad_first_in;
   logic        final_blk_ff, final_blk_in;

   logic [63:0]    len_bits;
   logic [7:0]     len_byte;
   rnd_ctrl_type   rctl;
   sched_ctrl_type sctl;
   word_type       w_cur;
   word_type       chain_words [CHAIN_WORDS];

   assign len_bits = {count_ff, 3'b000};
   assign len_byte = len_bits[{~fill_ff[2:0], 3'b000} +: 8];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      out_idx_in   = out_idx_ff;
      pend_last_in = pend_last_ff;
      in_pad_in    = in_pad_ff;
      pad_first_in = pad_first_ff;
      final_blk_in = final_blk_ff;
      rctl         = '0;
      rctl.round   = round_ff;
      sctl         = '0;
      sctl.data    = req_data_byte;
      sctl.word_end = (fill_ff[1:0] == 2'b11);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_valid) begin
                  sctl.push = 1'b1;
                  count_in  = count_ff + 61'd1;
                  fill_in   = fill_ff + 6'd1;
               end
               if (req_byte_valid && (fill_ff == 6'd63)) begin
                  rctl.load    = 1'b1;
                  round_in     = '0;
                  pend_last_in = req_last_byte;
                  state_in     = ST_ROUND;
               end else if (req_last_byte) begin
                  in_pad_in    = 1'b1;
                  pad_first_in = 1'b1;
                  final_blk_in = 1'b0;
                  state_in     = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            rctl.step  = 1'b1;
            sctl.shift = 1'b1;
            round_in   = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            rctl.fold = 1'b1;
            if (in_pad_ff) begin
               if (final_blk_ff) begin
                  out_idx_in = '0;
                  state_in   = ST_OUT;
               end else begin
                  // length did not fit: one more block of zeros and length
                  final_blk_in = 1'b1;
                  state_in     = ST_PAD;
               end
            end else if (pend_last_ff) begin
               in_pad_in    = 1'b1;
               pad_first_in = 1'b1;
               final_blk_in = 1'b0;
               state_in     = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            sctl.push = 1'b1;
            if (pad_first_ff) begin
               sctl.data = PAD_MARK;
            end else if (final_blk_ff && (fill_ff[5:3] == 3'b111)) begin
               sctl.data = len_byte;
            end else begin
               sctl.data = '0;
            end
            pad_first_in = 1'b0;
            if (pad_first_ff && (fill_ff[5:3] != 3'b111)) begin
               final_blk_in = 1'b1;
            end
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               rctl.load = 1'b1;
               round_in  = '0;
               state_in  = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (out_idx_ff == 3'd4) begin
                  rctl.init    = 1'b1;
                  count_in     = '0;
                  fill_in      = '0;
                  in_pad_in    = 1'b0;
                  pend_last_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fill_ff      <= '0;
         round_ff     <= '0;
         out_idx_ff   <= '0;
         pend_last_ff <= 1'b0;
         in_pad_ff    <= 1'b0;
         pad_first_ff <= 1'b0;
         final_blk_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         pend_last_ff <= pend_last_in;
         in_pad_ff    <= in_pad_in;
         pad_first_ff <= pad_first_in;
         final_blk_ff <= final_blk_in;
      end
   end

   sha1he_sched u_sched (
      .clock (clock),
      .ctrl  (sctl),
      .w_cur (w_cur)
   );

   sha1he_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (rctl),
      .w_cur       (w_cur),
      .chain_words (chain_words)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_words[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_digest_end  = (out_idx_ff == 3'd4);

endmodule

// ----- rtl/sha1he_check.sv -----
// Port-level checks for the SHA-1 hash engine, bound to the top level.
// Depends on sha1_hash_engine's port list only.
module sha1he_check (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_digest_end
);

   // hold a stalled digest word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word))
      else $error("stalled digest word changed");

   // no request taken while a digest is out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted during digest output");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_end == (rsp_word_index == 3'd4)))
      else $error("digest end flag out of place");

   // words advance one index at a time until the end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_digest_end |=>
         rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word sequence broken");

endmodule

bind sha1_hash_engine sha1he_check u_sha1he_check (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_digest_end  (rsp_digest_end)
);
